FILE: rtl/core/fcad_pkg.sv
// package for the frequency change announce debounce core
// types, field widths and register codes shared by all rtl files; no dependencies
`timescale 1ns / 1ps

package fcad_pkg;

	localparam int unsigned HZ_W       = 36;
	localparam int unsigned MS_W       = 32;
	localparam int unsigned STEP_W     = 32;
	localparam int unsigned SHORT_MS_W = 16;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned IN_DATA_W  = 104;
	localparam int unsigned OUT_DATA_W = 40;

	localparam logic OP_REPORT = 1'b0;
	localparam logic OP_IDLE   = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_STEP_HZ      = 3'd0,
		REG_IDLE_MS          = 3'd1,
		REG_MIN_INTERVAL_MS  = 3'd2,
		REG_START_IMMEDIATE  = 3'd3,
		REG_SPEECH_EN        = 3'd4,
		REG_TUNING_SPEAK_EN  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [STEP_W-1:0]     min_step_hz;
		logic [SHORT_MS_W-1:0] idle_ms;
		logic [SHORT_MS_W-1:0] min_interval_ms;
		logic                  start_immediately;
		logic                  speech_enabled;
		logic                  tuning_speak_enabled;
	} cfg_t;

	typedef struct packed {
		logic            op;
		logic [HZ_W-1:0] freq_hz;
		logic [MS_W-1:0] now_ms;
		logic [MS_W-1:0] suppress_until_ms;
	} item_t;

	typedef struct packed {
		logic            announce;
		logic [HZ_W-1:0] announce_hz;
	} result_t;

endpackage

FILE: rtl/core/frequency_change_announce_debounce_core.sv
// channel  | group            | contents
// ---------+------------------+--------------------------------------------------
// input    | s_tvalid/tready  | tuser: op; tdata: freq_hz, now_ms, suppress_until_ms
// result   | m_tvalid/tready  | tuser: announce; tdata: announce_hz
// config   | cfg_we           | cfg_index selects register, cfg_wdata holds value
//
// one word per cycle unless the result side stalls; a word enters the input
// register, its decision is made against the tuning state registers and it is
// loaded into the result register, which drives m_tvalid.
// arst_n clears valid flags and tuning state; configuration returns to defaults.
// a stalled result holds the input register, which then drops s_tready.
//
// top level of the announce debounce core
// depends on fcad_pkg, fcad_cfg_regs, fcad_in_stage, fcad_engine, fcad_out_stage
`timescale 1ns / 1ps

module frequency_change_announce_debounce_core import fcad_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // freq_hz[35:0], now_ms, suppress_until_ms, zero pad
	input  logic                  s_tuser,   // op
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // announce_hz[35:0], zero pad
	output logic                  m_tuser,   // announce
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t    cfg;
	item_t   item;
	result_t result;
	logic    item_valid;
	logic    can_load;

	fcad_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	fcad_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.advance    (can_load),
		.item_valid (item_valid),
		.item       (item)
	);

	fcad_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item),
		.commit (item_valid && can_load),
		.result (result)
	);

	fcad_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (item_valid),
		.load       (result),
		.can_load   (can_load),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

FILE: rtl/core/fcad_cfg_regs.sv
// configuration register file of the announce debounce core
// depends on fcad_pkg
`timescale 1ns / 1ps

module fcad_cfg_regs import fcad_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_step_hz          <= '0;
			cfg_q.idle_ms              <= '0;
			cfg_q.min_interval_ms      <= '0;
			cfg_q.start_immediately    <= 1'b1;
			cfg_q.speech_enabled       <= 1'b1;
			cfg_q.tuning_speak_enabled <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MIN_STEP_HZ:     cfg_q.min_step_hz <= cfg_wdata[STEP_W-1:0];
				REG_IDLE_MS:         cfg_q.idle_ms <= cfg_wdata[SHORT_MS_W-1:0];
				REG_MIN_INTERVAL_MS: cfg_q.min_interval_ms <= cfg_wdata[SHORT_MS_W-1:0];
				REG_START_IMMEDIATE: cfg_q.start_immediately <= cfg_wdata[0];
				REG_SPEECH_EN:       cfg_q.speech_enabled <= cfg_wdata[0];
				REG_TUNING_SPEAK_EN: cfg_q.tuning_speak_enabled <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/core/fcad_in_stage.sv
// input register stage: captures one word per cycle from the slave side unless stalled
// depends on fcad_pkg
`timescale 1ns / 1ps

module fcad_in_stage import fcad_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,
	input  logic                 s_tuser,
	input  logic                 advance,
	output logic                 item_valid,
	output item_t                item
);

	logic  valid_s1;
	item_t item_s1;

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.op                <= s_tuser;
			item_s1.freq_hz           <= s_tdata[HZ_W-1:0];
			item_s1.now_ms            <= s_tdata[HZ_W+MS_W-1:HZ_W];
			item_s1.suppress_until_ms <= s_tdata[HZ_W+2*MS_W-1:HZ_W+MS_W];
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

FILE: rtl/core/fcad_engine.sv
// announce decision logic and tuning state of the debounce core
// depends on fcad_pkg
`timescale 1ns / 1ps

module fcad_engine import fcad_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  item_t   item,
	input  logic    commit,
	output result_t result
);

	logic            freq_known_q;
	logic [HZ_W-1:0] current_hz_q;
	logic            tuning_active_q;
	logic [HZ_W-1:0] pending_hz_q;
	logic [HZ_W-1:0] start_spoken_hz_q;
	logic [HZ_W-1:0] last_spoken_hz_q;
	logic [MS_W-1:0] last_spoken_ms_q;
	logic [MS_W-1:0] last_change_ms_q;

	logic [MS_W-1:0] until_diff;
	logic [MS_W-1:0] since_spoken;
	logic [MS_W-1:0] since_change;
	logic [HZ_W-1:0] step_abs;
	logic            suppressed;
	logic            interval_ok;
	logic            idle_ok;
	logic            changed;
	logic            step_ok;
	logic            track;
	logic [HZ_W-1:0] start_base;
	logic            speak_start;
	logic            idle_done;
	logic            speak_idle;

	always_comb begin
		until_diff   = item.now_ms - item.suppress_until_ms;
		suppressed   = until_diff[MS_W-1];
		since_spoken = item.now_ms - last_spoken_ms_q;
		since_change = item.now_ms - last_change_ms_q;
		interval_ok  = since_spoken >= {{(MS_W-SHORT_MS_W){1'b0}}, cfg.min_interval_ms};
		idle_ok      = since_change >= {{(MS_W-SHORT_MS_W){1'b0}}, cfg.idle_ms};
		step_abs     = (item.freq_hz > pending_hz_q) ? item.freq_hz - pending_hz_q
		                                             : pending_hz_q - item.freq_hz;
		// zero pending means nothing to filter against
		step_ok      = (pending_hz_q == '0)
		               || (step_abs >= {{(HZ_W-STEP_W){1'b0}}, cfg.min_step_hz});
		changed      = !freq_known_q || (item.freq_hz != current_hz_q);
		track        = (item.op == OP_REPORT) && changed && cfg.tuning_speak_enabled
		               && !suppressed && step_ok;
		// a new run forgets what was spoken at the start of the last one
		start_base   = tuning_active_q ? start_spoken_hz_q : '0;
		speak_start  = track && cfg.speech_enabled && cfg.start_immediately
		               && (start_base == '0) && interval_ok;
		idle_done    = (item.op == OP_IDLE) && cfg.speech_enabled
		               && cfg.tuning_speak_enabled && !suppressed && tuning_active_q
		               && (pending_hz_q != '0) && idle_ok && interval_ok;
		speak_idle   = idle_done && (pending_hz_q != last_spoken_hz_q);

		result.announce    = speak_start || speak_idle;
		result.announce_hz = speak_start ? item.freq_hz
		                   : (speak_idle ? pending_hz_q : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_known_q      <= 1'b0;
			current_hz_q      <= '0;
			tuning_active_q   <= 1'b0;
			pending_hz_q      <= '0;
			start_spoken_hz_q <= '0;
			last_spoken_hz_q  <= '0;
			last_spoken_ms_q  <= '0;
			last_change_ms_q  <= '0;
		end else if (commit) begin
			if (item.op == OP_REPORT) begin
				freq_known_q <= 1'b1;
				current_hz_q <= item.freq_hz;
			end
			if (track) begin
				tuning_active_q   <= 1'b1;
				pending_hz_q      <= item.freq_hz;
				last_change_ms_q  <= item.now_ms;
				start_spoken_hz_q <= speak_start ? item.freq_hz : start_base;
			end
			if (idle_done) begin
				tuning_active_q <= 1'b0;
			end
			if (result.announce) begin
				last_spoken_hz_q <= result.announce_hz;
				last_spoken_ms_q <= item.now_ms;
			end
		end
	end

endmodule

FILE: rtl/core/fcad_out_stage.sv
// result register toward the master side
// depends on fcad_pkg
`timescale 1ns / 1ps

module fcad_out_stage import fcad_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load_valid,
	input  result_t               load,
	output logic                  can_load,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tuser
);

	logic    valid_q;
	result_t result_q;

	// free when empty or when the held word leaves this cycle
	assign can_load = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load_valid) begin
			result_q <= load;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = result_q.announce;
	assign m_tdata  = {{(OUT_DATA_W-HZ_W){1'b0}}, result_q.announce_hz};

endmodule

FILE: rtl/core/fcad_port_checker.sv
// port level checks for the announce debounce core, bound to the top level
// depends on fcad_pkg and frequency_change_announce_debounce_core
`timescale 1ns / 1ps

module fcad_port_checker import fcad_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic                  m_tuser
);

	// a held result word does not change or vanish
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// silent result carries zero frequency
	a_silent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("nonzero frequency without announce");

	// input side only backs up behind a full result register
	a_ready_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with empty result register");

	// a fresh result word comes from an accepted word via the input register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !$past(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result word without matching input word");

	// no result word right after reset
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result valid coming out of reset");

endmodule

bind frequency_change_announce_debounce_core fcad_port_checker u_port_checker (.*);
